>>> hw/rtl/esm_pkg.sv
// Shared constants, types and rounding helper for the transform matrix block.
package esm_pkg;

  // Q.30 trig constants, reciprocal saturation value and Q16.16 one
  localparam logic signed [31:0] Q_ONE      = 32'sd1073741824;
  localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [31:0] RECIP_SAT  = 32'sh7FFFFFFF;
  localparam logic [31:0]        MODEL_ONE  = 32'd65536;

  // series steps, divisors from the innermost factor outwards
  localparam int N_STEP     = 6;
  localparam int N_SIN_STEP = 5;
  localparam logic [7:0]  SIN_DIV [N_SIN_STEP] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0]  COS_DIV [N_STEP] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  // floor(2^32 / divisor)
  localparam logic [31:0] SIN_RCP [N_SIN_STEP] = '{32'd39045157, 32'd59652323,
    32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_RCP [N_STEP] = '{32'd32537631, 32'd47721858,
    32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

  // pipeline depths
  localparam int SC_LAT    = 3 + 3 * N_STEP + 2;
  localparam int MAT_LAT   = 3;
  localparam int REC_BITS  = 31;
  localparam int RC_LAT    = REC_BITS + 2;
  localparam int ANG_PAD   = RC_LAT - SC_LAT - MAT_LAT;
  localparam int FRONT_LAT = RC_LAT + 2;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0] COL_LAST = 2'd3;

  typedef struct packed {
    logic signed [31:0] shift_z;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_x;
    logic signed [15:0] scale_z;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] angle_z;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_x;
  } in_item_t;

  // one finished transform: [column][row]
  typedef struct packed {
    logic [2:0][2:0][31:0] model;
    logic [2:0][2:0][31:0] normal;
    logic [2:0][31:0]      shift;
    logic                  zero;
  } esm_rec_t;

  // one column word
  typedef struct packed {
    logic [1:0]       col;
    logic [2:0][31:0] normal;
    logic [3:0][31:0] model;
    logic             zero;
    logic             last;
  } esm_col_t;

  // shift right by n, round half away from zero
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input int unsigned n);
    logic [65:0] mag;
    logic [65:0] half;
    half = 66'd1 << (n - 1);
    mag = v[65] ? $unsigned(-v) : $unsigned(v);
    mag = (mag + half) >> n;
    rnd_shift = v[65] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

>>> hw/rtl/esm_sincos.sv
// Pipelined Q.30 sine and cosine of a Q4.12 angle, one angle per cycle while en is high.
module esm_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  typedef struct packed {
    logic [31:0]        x2;
    logic signed [31:0] z;
    logic               flip;
    logic signed [31:0] ps;
    logic signed [31:0] pc;
  } esc_carry_t;

  logic signed [34:0] z_raw, z_wrap, z_fold;
  logic               flip;
  logic signed [31:0] z0_r, z1_r, z2_r;
  logic               flip0_r, flip1_r, flip2_r;
  logic signed [63:0] zz_r;
  logic [63:0]        zz_sum;
  logic [31:0]        x2_r;
  esc_carry_t         init_c;
  esc_carry_t         cc_r [esm_pkg::N_STEP];
  logic signed [63:0] sraw_r;
  logic signed [31:0] pcf_r;
  logic               flipf_r;
  logic signed [65:0] sn;
  logic signed [31:0] sin_r, cos_r;

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    z_raw = {angle_i[15], angle_i, 18'd0};
    if (z_raw > esm_pkg::PI_Q30) begin
      z_wrap = z_raw - esm_pkg::TWO_PI_Q30;
    end else if (z_raw < -esm_pkg::PI_Q30) begin
      z_wrap = z_raw + esm_pkg::TWO_PI_Q30;
    end else begin
      z_wrap = z_raw;
    end
    flip = 1'b0;
    z_fold = z_wrap;
    if (z_wrap > esm_pkg::HALF_PI_Q30) begin
      z_fold = z_wrap - esm_pkg::PI_Q30;
      flip = 1'b1;
    end else if (z_wrap < -esm_pkg::HALF_PI_Q30) begin
      z_fold = z_wrap + esm_pkg::PI_Q30;
      flip = 1'b1;
    end
  end

  assign zz_sum = $unsigned(zz_r) + 64'd536870912;

  // reduce, square, round the square
  always_ff @(posedge clk) begin
    if (en) begin
      z0_r    <= z_fold[31:0];
      flip0_r <= flip;
      zz_r    <= z0_r * z0_r;
      z1_r    <= z0_r;
      flip1_r <= flip0_r;
      x2_r    <= zz_sum[61:30];
      z2_r    <= z1_r;
      flip2_r <= flip1_r;
    end
  end

  assign init_c = '{x2: x2_r, z: z2_r, flip: flip2_r, ps: esm_pkg::Q_ONE,
                    pc: esm_pkg::Q_ONE};

  // one series factor per step: multiply, scale by reciprocal, correct
  for (genvar i = 0; i < esm_pkg::N_STEP; i++) begin : g_step
    esc_carry_t         cin, cm_r, cq_r;
    logic [62:0]        prc_r, sumc;
    logic [63:0]        estc;
    logic [31:0]        qc_r, ec_r, quotc;
    logic [39:0]        remc;
    logic signed [31:0] pc_new, ps_new;

    if (i == 0) begin : g_first
      assign cin = init_c;
    end else begin : g_next
      assign cin = cc_r[i-1];
    end

    always_comb begin
      sumc  = prc_r + 63'd536870912;
      estc  = 64'(sumc[61:30]) * 64'(esm_pkg::COS_RCP[i]);
      remc  = 40'(qc_r) - 40'(ec_r) * 40'(esm_pkg::COS_DIV[i]);
      quotc = ec_r + 32'(remc >= 40'(esm_pkg::COS_DIV[i]));
      pc_new = 32'(esm_pkg::Q_ONE - $signed({1'b0, quotc}));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cm_r  <= cin;
        prc_r <= cin.x2 * cin.pc[30:0];
        cq_r  <= cm_r;
        qc_r  <= sumc[61:30];
        ec_r  <= estc[63:32];
      end
    end

    if (i < esm_pkg::N_SIN_STEP) begin : g_sin
      logic [62:0] prs_r, sums;
      logic [63:0] ests;
      logic [31:0] qs_r, es_r, quots;
      logic [39:0] rems;

      always_comb begin
        sums  = prs_r + 63'd536870912;
        ests  = 64'(sums[61:30]) * 64'(esm_pkg::SIN_RCP[i]);
        rems  = 40'(qs_r) - 40'(es_r) * 40'(esm_pkg::SIN_DIV[i]);
        quots = es_r + 32'(rems >= 40'(esm_pkg::SIN_DIV[i]));
      end

      assign ps_new = 32'(esm_pkg::Q_ONE - $signed({1'b0, quots}));

      always_ff @(posedge clk) begin
        if (en) begin
          prs_r <= cin.x2 * cin.ps[30:0];
          qs_r  <= sums[61:30];
          es_r  <= ests[63:32];
        end
      end
    end else begin : g_sin_hold
      assign ps_new = cq_r.ps;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cc_r[i] <= '{x2: cq_r.x2, z: cq_r.z, flip: cq_r.flip, ps: ps_new, pc: pc_new};
      end
    end
  end

  assign sn = esm_pkg::rnd_shift(66'(sraw_r), 30);

  // final sine product and sign restore
  always_ff @(posedge clk) begin
    if (en) begin
      sraw_r  <= cc_r[esm_pkg::N_STEP-1].z * cc_r[esm_pkg::N_STEP-1].ps;
      pcf_r   <= cc_r[esm_pkg::N_STEP-1].pc;
      flipf_r <= cc_r[esm_pkg::N_STEP-1].flip;
      sin_r   <= flipf_r ? -sn[31:0] : sn[31:0];
      cos_r   <= flipf_r ? -pcf_r : pcf_r;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> hw/rtl/esm_recip.sv
// Pipelined Q10.22 reciprocal of a Q8.8 scale, one quotient bit per stage.
module esm_recip (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] scale_i,
  output logic signed [31:0] recip_o
);

  typedef struct packed {
    logic [15:0] m;
    logic [30:0] n;
    logic [30:0] q;
    logic [15:0] rem;
    logic        neg;
    logic        zero;
  } erc_div_t;

  logic [15:0] mag;
  erc_div_t    init_d;
  erc_div_t    dv_r [esm_pkg::REC_BITS];
  logic signed [31:0] recip_r;
  erc_div_t    dv_last;

  assign mag = scale_i[15] ? 16'(-scale_i) : 16'(scale_i);

  // latch divisor and rounded dividend 2^30 + m/2
  always_ff @(posedge clk) begin
    if (en) begin
      init_d <= '{m: mag, n: 31'h4000_0000 + 31'(mag >> 1), q: '0, rem: '0,
                  neg: scale_i[15], zero: (scale_i == 16'sd0)};
    end
  end

  // restoring division, most significant bit first
  for (genvar k = 0; k < esm_pkg::REC_BITS; k++) begin : g_bit
    erc_div_t    din, dout;
    logic [16:0] t;

    if (k == 0) begin : g_first
      assign din = init_d;
    end else begin : g_next
      assign din = dv_r[k-1];
    end

    always_comb begin
      dout = din;
      t = {din.rem, din.n[esm_pkg::REC_BITS-1-k]};
      if (t >= {1'b0, din.m}) begin
        dout.rem = 16'(t - {1'b0, din.m});
        dout.q[esm_pkg::REC_BITS-1-k] = 1'b1;
      end else begin
        dout.rem = t[15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= dout;
      end
    end
  end

  assign dv_last = dv_r[esm_pkg::REC_BITS-1];

  // saturate a zero scale, restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_last.zero) begin
        recip_r <= esm_pkg::RECIP_SAT;
      end else if (dv_last.neg) begin
        recip_r <= -$signed({1'b0, dv_last.q});
      end else begin
        recip_r <= $signed({1'b0, dv_last.q});
      end
    end
  end

  assign recip_o = recip_r;

endmodule

>>> hw/rtl/esm_front.sv
// Front end: accepts transforms and computes the full column set in a stall-all pipeline.
module esm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  esm_pkg::in_item_t in_item_i,
  output logic              rec_valid_o,
  input  logic              rec_ready_i,
  output esm_pkg::esm_rec_t rec_o
);

  typedef struct packed {
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } efr_ang_t;

  typedef struct packed {
    logic [2:0][31:0]        shift;
    logic signed [2:0][15:0] scale;
  } efr_side_t;

  logic               en;
  logic [esm_pkg::FRONT_LAT-1:0] vld_r;
  efr_ang_t           ang_r [esm_pkg::ANG_PAD];
  efr_side_t          side_r [esm_pkg::RC_LAT];
  efr_ang_t           ang_d;
  efr_side_t          side_d;
  logic signed [31:0] s1, c1, s2, c2, s3, c3;
  logic signed [31:0] rc [3];

  logic signed [63:0] p_c1c3_r, p_s1s2_r, p_c2s3_r, p_c1s2_r, p_c3s1_r;
  logic signed [63:0] p_c1s3_r, p_c2c3_r, p_s1s3_r, p_c2s1_r, p_c1c2_r;
  logic signed [31:0] s2_t1_r, s3_t1_r, s2_t2_r;
  logic signed [31:0] r_c1c3_r, r_c2s3_r, r_c3s1_r, r_c1s3_r;
  logic signed [31:0] r_c2c3_r, r_s1s3_r, r_c2s1_r, r_c1c2_r;
  logic signed [63:0] p_s1s2s3_r, p_c1s2s3_r, p_c3s1s2_r, p_c1c3s2_r;
  logic signed [32:0] rot_r [3][3];
  logic signed [48:0] mraw_r [3][3];
  logic signed [64:0] nraw_r [3][3];
  logic [2:0][31:0]   shift_p1_r;
  logic               zero_p1_r;
  esm_pkg::esm_rec_t  rec_r;

  function automatic logic signed [31:0] rq(input logic signed [63:0] v);
    logic signed [65:0] t;
    t = esm_pkg::rnd_shift(66'(v), 30);
    rq = t[31:0];
  endfunction

  // advance everything together unless the last stage is blocked
  assign en = !vld_r[esm_pkg::FRONT_LAT-1] || rec_ready_i;
  assign in_ready_o = en;
  assign rec_valid_o = vld_r[esm_pkg::FRONT_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[esm_pkg::FRONT_LAT-2:0], in_valid_i};
    end
  end

  // delay angles and the side data to line up with the reciprocals
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= '{az: in_item_i.angle_z, ay: in_item_i.angle_y, ax: in_item_i.angle_x};
      for (int k = 1; k < esm_pkg::ANG_PAD; k++) ang_r[k] <= ang_r[k-1];
      side_r[0] <= '{shift: {in_item_i.shift_z, in_item_i.shift_y, in_item_i.shift_x},
                     scale: {in_item_i.scale_z, in_item_i.scale_y, in_item_i.scale_x}};
      for (int k = 1; k < esm_pkg::RC_LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  assign ang_d  = ang_r[esm_pkg::ANG_PAD-1];
  assign side_d = side_r[esm_pkg::RC_LAT-1];

  esm_sincos u_sc_y (.clk(clk), .en(en), .angle_i(ang_d.ay), .sin_o(s1), .cos_o(c1));
  esm_sincos u_sc_x (.clk(clk), .en(en), .angle_i(ang_d.ax), .sin_o(s2), .cos_o(c2));
  esm_sincos u_sc_z (.clk(clk), .en(en), .angle_i(ang_d.az), .sin_o(s3), .cos_o(c3));

  esm_recip u_rc_x (.clk(clk), .en(en), .scale_i(in_item_i.scale_x), .recip_o(rc[0]));
  esm_recip u_rc_y (.clk(clk), .en(en), .scale_i(in_item_i.scale_y), .recip_o(rc[1]));
  esm_recip u_rc_z (.clk(clk), .en(en), .scale_i(in_item_i.scale_z), .recip_o(rc[2]));

  // rotation terms: pair products, triple products, sums
  always_ff @(posedge clk) begin
    if (en) begin
      p_c1c3_r <= c1 * c3;
      p_s1s2_r <= s1 * s2;
      p_c2s3_r <= c2 * s3;
      p_c1s2_r <= c1 * s2;
      p_c3s1_r <= c3 * s1;
      p_c1s3_r <= c1 * s3;
      p_c2c3_r <= c2 * c3;
      p_s1s3_r <= s1 * s3;
      p_c2s1_r <= c2 * s1;
      p_c1c2_r <= c1 * c2;
      s2_t1_r  <= s2;
      s3_t1_r  <= s3;

      r_c1c3_r   <= rq(p_c1c3_r);
      r_c2s3_r   <= rq(p_c2s3_r);
      r_c3s1_r   <= rq(p_c3s1_r);
      r_c1s3_r   <= rq(p_c1s3_r);
      r_c2c3_r   <= rq(p_c2c3_r);
      r_s1s3_r   <= rq(p_s1s3_r);
      r_c2s1_r   <= rq(p_c2s1_r);
      r_c1c2_r   <= rq(p_c1c2_r);
      p_s1s2s3_r <= rq(p_s1s2_r) * s3_t1_r;
      p_c1s2s3_r <= rq(p_c1s2_r) * s3_t1_r;
      p_c3s1s2_r <= rq(p_c3s1_r) * s2_t1_r;
      p_c1c3s2_r <= rq(p_c1c3_r) * s2_t1_r;
      s2_t2_r    <= s2_t1_r;

      rot_r[0][0] <= 33'(r_c1c3_r) + 33'(rq(p_s1s2s3_r));
      rot_r[0][1] <= 33'(r_c2s3_r);
      rot_r[0][2] <= 33'(rq(p_c1s2s3_r)) - 33'(r_c3s1_r);
      rot_r[1][0] <= 33'(rq(p_c3s1s2_r)) - 33'(r_c1s3_r);
      rot_r[1][1] <= 33'(r_c2c3_r);
      rot_r[1][2] <= 33'(rq(p_c1c3s2_r)) + 33'(r_s1s3_r);
      rot_r[2][0] <= 33'(r_c2s1_r);
      rot_r[2][1] <= -33'(s2_t2_r);
      rot_r[2][2] <= 33'(r_c1c2_r);
    end
  end

  // scale and reciprocal products, then round to Q16.16
  always_ff @(posedge clk) begin
    logic signed [65:0] tm, tn;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          mraw_r[c][r] <= $signed(side_d.scale[c]) * rot_r[c][r];
          nraw_r[c][r] <= rc[c] * rot_r[c][r];
          tm = esm_pkg::rnd_shift(66'(mraw_r[c][r]), 22);
          tn = esm_pkg::rnd_shift(66'(nraw_r[c][r]), 36);
          rec_r.model[c][r]  <= tm[31:0];
          rec_r.normal[c][r] <= tn[31:0];
        end
      end
      shift_p1_r  <= side_d.shift;
      zero_p1_r   <= (side_d.scale[0] == 16'sd0) || (side_d.scale[1] == 16'sd0) ||
                     (side_d.scale[2] == 16'sd0);
      rec_r.shift <= shift_p1_r;
      rec_r.zero  <= zero_p1_r;
    end
  end

  assign rec_o = rec_r;

endmodule

>>> hw/rtl/esm_fifo.sv
// Short queue of finished column sets between front and back.
module esm_fifo #(
  parameter int DEPTH = esm_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  output logic              ready_o,
  input  esm_pkg::esm_rec_t data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output esm_pkg::esm_rec_t data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  esm_pkg::esm_rec_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign ready_o = (count_r != CW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_r[rd_ptr_r];

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

>>> hw/rtl/esm_back.sv
// Back end: walks the queued column set and drives one column word per cycle while the receiver is ready.
module esm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid_i,
  input  esm_pkg::esm_rec_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output esm_pkg::esm_col_t out_o
);

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        col_r, col_nxt;
  esm_pkg::esm_col_t out_r, out_nxt;
  esm_pkg::esm_col_t word;
  logic              load;

  assign load  = !out_valid_r || out_ready_i;
  assign pop_o = load && head_valid_i && (col_r == esm_pkg::COL_LAST);

  // select the current column
  always_comb begin
    word.col  = col_r;
    word.zero = head_i.zero;
    word.last = (col_r == esm_pkg::COL_LAST);
    case (col_r)
      esm_pkg::COL_LAST: begin
        word.model  = {esm_pkg::MODEL_ONE, head_i.shift};
        word.normal = '0;
      end
      default: begin
        word.model  = {32'd0, head_i.model[col_r]};
        word.normal = head_i.normal[col_r];
      end
    endcase
  end

  // load the output register when it is free or being taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt = head_valid_i;
      if (head_valid_i) begin
        out_nxt = word;
        col_nxt = col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_o       = out_r;

  a_last_on_col3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.last == (out_r.col == esm_pkg::COL_LAST)))
    else $error("last flag does not match column index");

  a_col_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready_i && !out_r.last) |=>
      (out_valid_r && (out_r.col == $past(out_r.col) + 2'd1)))
    else $error("column words of one transform not contiguous");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> (out_valid_r && out_r.last))
    else $error("queue popped before the last column was loaded");

endmodule

>>> hw/rtl/euler_scale_translate_matrix.sv
// Top level: object transform in, model and normal matrix columns out.
//
// Input stream: one transform per word (three Q4.12 angles, three Q8.8
// scales, three Q16.16 translations). Output stream: four words per
// transform, columns 0 to 3 in order, tlast on column 3. Each word holds
// a model column (four Q16.16 rows) and a normal column (three rows);
// tuser carries the column index and the zero-scale flag.
// Path: a transform passes the 33-stage reciprocal pipeline (its first
// stage loads on the accepting edge), two product stages, the queue write
// and the output register before its first column leaves. Throughput is
// set by the output port moving one column per cycle while the receiver
// is ready; the input side takes a word per cycle while the queue has
// room.
// A zero scale gives a saturated reciprocal and raises the flag in all
// four words of that transform.
// Reset clears the valid bits, the queue and the column counter.
// When the receiver stalls the output word holds, the queue fills, and
// then the whole front pipeline freezes and in_tready drops.
module euler_scale_translate_matrix #(
  parameter int FIFO_DEPTH = esm_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, shift_x, shift_y, shift_z
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // model_row0, model_row1, model_row2, model_row3, normal_row0, normal_row1, normal_row2
  output logic [223:0] out_tdata,
  // column_index[1:0], zero_scale
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  esm_pkg::in_item_t in_item;
  esm_pkg::esm_rec_t rec, head;
  esm_pkg::esm_col_t col;
  logic              rec_valid, rec_ready, head_valid, pop;

  assign in_item = in_tdata;

  esm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .in_item_i   (in_item),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  esm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (rec_valid),
    .ready_o (rec_ready),
    .data_i  (rec),
    .valid_o (head_valid),
    .pop_i   (pop),
    .data_o  (head)
  );

  esm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_o        (col)
  );

  assign out_tdata = {col.normal, col.model};
  assign out_tuser = {col.zero, col.col};
  assign out_tlast = col.last;

endmodule

>>> tb/esm_checker.sv
// Checker: predicts model and normal matrix columns for each transform and compares them.
module esm_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [223:0] out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint PI_FIX    = 64'sd3373259426;
  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint RECIP_MAX = 64'sh7FFFFFFF;

  typedef struct {
    logic [1:0]  col;
    logic [31:0] model [4];
    logic [31:0] normal [3];
    logic        zero;
    logic        last;
  } column_t;

  column_t column_queue [$];

  // round half away from zero, then shift right by n
  function automatic longint round_shift(longint v, int n);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint mul30(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  task automatic sine_cosine(input logic signed [15:0] ang, output longint sn,
                             output longint cs);
    longint z, x2, p;
    bit flip;
    longint sdiv [5];
    longint cdiv [6];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    z = longint'(ang) * 262144;
    flip = 0;
    while (z > PI_FIX) z -= 2 * PI_FIX;
    while (z < -PI_FIX) z += 2 * PI_FIX;
    if (z > HALF_PI) begin
      z -= PI_FIX;
      flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI_FIX;
      flip = 1;
    end
    x2 = mul30(z, z);
    p = ONE_Q30;
    for (int i = 0; i < 5; i++) p = ONE_Q30 - mul30(x2, p) / sdiv[i];
    sn = mul30(z, p);
    p = ONE_Q30;
    for (int i = 0; i < 6; i++) p = ONE_Q30 - mul30(x2, p) / cdiv[i];
    cs = p;
    if (flip) begin
      sn = -sn;
      cs = -cs;
    end
  endtask

  function automatic longint scale_recip(longint s);
    longint m;
    if (s == 0) return RECIP_MAX;
    m = (s < 0) ? -s : s;
    m = (ONE_Q30 + m / 2) / m;
    return (s < 0) ? -m : m;
  endfunction

  // build the four expected columns of one transform
  task automatic predict_columns(input logic [191:0] word);
    longint s1, c1, s2, c2, s3, c3;
    longint rot [3][3];
    longint sc [3];
    longint rc [3];
    bit zero;
    column_t c;
    sine_cosine(word[31:16], s1, c1);
    sine_cosine(word[15:0], s2, c2);
    sine_cosine(word[47:32], s3, c3);
    rot[0][0] = mul30(c1, c3) + mul30(mul30(s1, s2), s3);
    rot[0][1] = mul30(c2, s3);
    rot[0][2] = mul30(mul30(c1, s2), s3) - mul30(c3, s1);
    rot[1][0] = mul30(mul30(c3, s1), s2) - mul30(c1, s3);
    rot[1][1] = mul30(c2, c3);
    rot[1][2] = mul30(mul30(c1, c3), s2) + mul30(s1, s3);
    rot[2][0] = mul30(c2, s1);
    rot[2][1] = -s2;
    rot[2][2] = mul30(c1, c2);
    zero = 0;
    for (int k = 0; k < 3; k++) begin
      sc[k] = longint'($signed(word[48 + 16*k +: 16]));
      if (sc[k] == 0) zero = 1;
      rc[k] = scale_recip(sc[k]);
    end
    for (int k = 0; k < 3; k++) begin
      c.col = k[1:0];
      for (int r = 0; r < 3; r++) begin
        c.model[r]  = 32'(round_shift(sc[k] * rot[k][r], 22));
        c.normal[r] = 32'(round_shift(rc[k] * rot[k][r], 36));
      end
      c.model[3] = '0;
      c.zero = zero;
      c.last = 0;
      column_queue.push_back(c);
    end
    c.col = 2'd3;
    for (int r = 0; r < 3; r++) begin
      c.model[r] = word[96 + 32*r +: 32];
      c.normal[r] = '0;
    end
    c.model[3] = 32'd65536;
    c.zero = zero;
    c.last = 1;
    column_queue.push_back(c);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  // watch both channels at each rising edge
  always @(posedge clk) begin
    column_t e;
    if (rst_n && in_tvalid && in_tready) predict_columns(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (column_queue.size() == 0) begin
        $error("column word with no transform pending");
        fail_count++;
      end else begin
        e = column_queue.pop_front();
        check_field("column_index", 32'(e.col), 32'(out_tuser[1:0]));
        check_field("zero_scale", 32'(e.zero), 32'(out_tuser[2]));
        check_field("last_column", 32'(e.last), 32'(out_tlast));
        for (int r = 0; r < 4; r++)
          check_field($sformatf("model_row%0d", r), e.model[r], out_tdata[32*r +: 32]);
        for (int r = 0; r < 3; r++)
          check_field($sformatf("normal_row%0d", r), e.normal[r],
                      out_tdata[128 + 32*r +: 32]);
      end
    end
    pending_count = column_queue.size();
  end
endmodule

>>> tb/tb.sv
// Testbench top: drives transforms and receiver stalls, reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [223:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           pending_count;
  bit           hold_off;
  bit           calm_sender;
  bit           calm_receiver;

  euler_scale_translate_matrix u_dut (.*);

  esm_checker u_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'($urandom_range(0, 600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [191:0] random_transform();
    logic [191:0] w;
    for (int k = 0; k < 6; k++) w[16*k +: 16] = pick16();
    for (int k = 0; k < 3; k++) w[96 + 32*k +: 32] = $urandom;
    // keep most scales nonzero so the zero flag stays a special case
    for (int k = 3; k < 6; k++)
      if (w[16*k +: 16] == 0 && $urandom_range(0, 3) != 0) w[16*k +: 16] = 16'h0100;
    return w;
  endfunction

  // idle at random, then offer one transform word and hold until accepted
  task automatic send_transform(input logic [191:0] w);
    while (!calm_sender && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [191:0] make_transform(logic [15:0] a, logic [15:0] s,
                                                  logic [31:0] t);
    return {t, t, t, s, s, s, a, a, a};
  endfunction

  // receiver: random stalls, calm stretch, one long hold-off
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if (calm_receiver) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 99) >= 23);
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int guard;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_off = 0;
    calm_sender = 0;
    calm_receiver = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, zero scales, angle wraps
    send_transform('0);
    send_transform(make_transform(16'h7FFF, 16'h7FFF, 32'h7FFFFFFF));
    send_transform(make_transform(16'h8000, 16'h8000, 32'h80000000));
    send_transform(make_transform(16'h1922, 16'h0100, 32'h00010000));
    send_transform(make_transform(16'hE6DE, 16'hFF00, 32'hFFFF0000));
    send_transform(make_transform(16'h3244, 16'h0001, 32'h00000001));
    send_transform(make_transform(16'hCDBC, 16'hFFFF, 32'hFFFFFFFF));
    send_transform({96'h0, 16'h0, 16'h0100, 16'h0100, 48'h123456789ABC});
    send_transform({96'h0, 16'h0100, 16'h0, 16'h0100, 48'h0});
    send_transform({96'h0, 16'h0100, 16'h0100, 16'h0, 48'h0});
    send_transform({32'h0, 32'hFFFFFFFF, 32'h55555555, 48'hFFFFAAAA5555,
                    16'h0C90, 16'hF370, 16'h6487});
    send_transform({192{1'b1}});

    // random with long hold-off while the sender keeps offering
    for (int n = 0; n < 280; n++) begin
      if (n == 60) begin
        fork
          begin
            hold_off = 1;
            repeat (150) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      calm_sender = (n >= 120 && n < 170);
      calm_receiver = (n >= 120 && n < 170);
      send_transform(random_transform());
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending_count != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
